// ===== design/gckr_pkg.sv =====
// Shared constants for the grid-cells-within-kernel-radius unit.
// Holds configuration register indexes and fixed field widths; no dependencies.
`default_nettype none
package gckr_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 31;
	localparam int unsigned CELL_W     = 12;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned DIM_W      = 13;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_GRID_SPACING  = 3'd0;
	localparam cfg_idx_t REG_KERNEL_RADIUS = 3'd1;
	localparam cfg_idx_t REG_GRID_CELLS_X  = 3'd2;
	localparam cfg_idx_t REG_GRID_CELLS_Y  = 3'd3;
	localparam cfg_idx_t REG_GRID_CELLS_Z  = 3'd4;
	localparam cfg_idx_t REG_THREE_DIMS    = 3'd5;

endpackage
`default_nettype wire

// ===== design/grid_cells_within_kernel_radius_unit.sv =====
// Grid-cells-within-kernel-radius unit: lists the grid cells around a particle.
// Per position the shared divider and the axis setup run for x, y and z in 3-D mode and for x
// and y in 2-D mode; the walk then checks 27, 9 or 1 candidate cells and can stall on m_tready.
// A new position is taken only in idle, once the previous list's tlast beat is registered.
// Reset (arst_n low, asynchronous) restores the default registers and empties the block.
// Depends on gckr_pkg.
`default_nettype none
module grid_cells_within_kernel_radius_unit #(
	parameter int MAX_SPAN   = 1,
	parameter int INDEX_BITS = 12
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire gckr_pkg::cfg_idx_t       cfg_index,
	input  wire [gckr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	// s_tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
	input  wire [95:0]                    s_tdata,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// m_tdata: cell_i [11:0], cell_j [23:12], cell_k [35:24], zero fill [39:36]
	output logic [39:0]                   m_tdata,
	// m_tuser: cell_valid [0]
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import gckr_pkg::*;

	// The position is split per axis into a home cell and a remainder by a
	// restoring divider that is shared by the axes, one quotient bit a
	// cycle. For each axis the three candidate offsets then get their doubled
	// distance to the cell center (2*rem - (2*o+1)*s, no multiply needed), an
	// in-grid flag and a square from the one shared multiplier. The walk then
	// checks one candidate cell a cycle, pausing while a found cell waits on
	// the output. One found cell is held back so that the final one can carry
	// tlast; an empty list gives a single beat with cell_valid low.

	localparam logic [16:0] DIM_LIM = 17'(1) << INDEX_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_DIVF, ST_AXD, ST_AXM, ST_WALK, ST_FIN
	} state_t;

	state_t state_q;

	logic [30:0] spacing_q, radius_q;
	logic [12:0] cells_x_q, cells_y_q, cells_z_q;
	logic        three_dims_q;

	logic [31:0] py_q, pz_q;
	logic [1:0]  axis_q, o_q;
	logic [4:0]  cnt_q;
	logic [31:0] acc_q, quo_q;
	logic        neg_q;
	logic [33:0] h_q;
	logic [30:0] rem_q;
	logic [31:0] ax_q;
	logic [63:0] r2_q;
	logic        span_q;
	logic [63:0] sqx_q [3];
	logic [63:0] sqy_q [3];
	logic [63:0] sqz_q [3];
	logic [11:0] idxx_q [3];
	logic [11:0] idxy_q [3];
	logic [11:0] idxz_q [3];
	logic [2:0]  okx_q, oky_q, okz_q;
	logic [1:0]  ci_q, cj_q, ck_q;
	logic [35:0] held_cell_q;
	logic        held_valid_q;
	logic        out_valid_q, out_cv_q, out_last_q;
	logic [35:0] out_cell_q;

	// Effective spacing and limits.
	logic [30:0] s_eff;
	logic [31:0] lim;
	logic [16:0] dim_sel;
	logic [31:0] pos_next, pos_abs;
	assign s_eff = (spacing_q == 31'd0) ? 31'd1 : spacing_q;
	assign lim   = {radius_q, 1'b0};

	always_comb begin
		logic [16:0] d;
		unique case (axis_q)
			2'd0: d = {4'b0, cells_x_q};
			2'd1: d = {4'b0, cells_y_q};
			default: d = {4'b0, cells_z_q};
		endcase
		dim_sel = (d > DIM_LIM) ? DIM_LIM : d;
	end

	// Position for the axis after the current one.
	assign pos_next = (axis_q == 2'd0) ? py_q : pz_q;
	assign pos_abs  = pos_next[31] ? (~pos_next + 32'd1) : pos_next;

	// Divider step.
	logic [31:0] trial, acc_n;
	logic        ge;
	assign trial = {acc_q[30:0], quo_q[31]};
	assign ge    = trial >= {1'b0, s_eff};
	assign acc_n = ge ? (trial - {1'b0, s_eff}) : trial;

	// Axis distance for one offset.
	logic [34:0] rem2, s35, cdist;
	logic [33:0] ax_abs, cand;
	logic        in_grid, ax_lt;
	always_comb begin
		rem2 = {3'b0, rem_q, 1'b0};
		s35  = {4'b0, s_eff};
		case (o_q)
			2'd0:    cdist = rem2 + s35;
			2'd1:    cdist = rem2 - s35;
			default: cdist = rem2 - s35 - {s35[33:0], 1'b0};
		endcase
		ax_abs  = cdist[34] ? 34'(~cdist + 35'd1) : cdist[33:0];
		ax_lt   = ax_abs < {2'b0, lim};
		cand    = h_q + 34'(o_q) - 34'd1;
		in_grid = !cand[33] && (cand[32:0] < {16'b0, dim_sel});
	end

	// Shared multiplier: squares during setup, doubled-radius square after the first divide.
	logic [31:0] mul_a;
	logic [63:0] prod;
	assign mul_a = (state_q == ST_AXM) ? ax_q : lim;
	assign prod  = mul_a * mul_a;

	// Candidate check during the walk.
	logic [63:0] sqz_e;
	logic        okz_e, pass;
	logic [65:0] sum;
	logic [11:0] k_e;
	logic        out_free;
	assign sqz_e    = three_dims_q ? sqz_q[ck_q] : 64'd0;
	assign okz_e    = three_dims_q ? okz_q[ck_q] : 1'b1;
	assign k_e      = three_dims_q ? idxz_q[ck_q] : 12'd0;
	assign sum      = 66'(sqx_q[ci_q]) + 66'(sqy_q[cj_q]) + 66'(sqz_e);
	assign pass     = okx_q[ci_q] && oky_q[cj_q] && okz_e && (sum < 66'(r2_q));
	assign out_free = !out_valid_q || m_tready;

	logic [1:0] st, en, kst, ken;
	assign st  = span_q ? 2'd0 : 2'd1;
	assign en  = span_q ? 2'd2 : 2'd1;
	assign kst = (span_q && three_dims_q) ? 2'd0 : 2'd1;
	assign ken = (span_q && three_dims_q) ? 2'd2 : 2'd1;

	logic walk_go;
	assign walk_go = !pass || !held_valid_q || out_free;

	// The output register takes a new beat when the walk passes on a held cell
	// or when the list is closed.
	logic out_load;
	assign out_load = ((state_q == ST_WALK) && walk_go && pass && held_valid_q) ||
		((state_q == ST_FIN) && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			spacing_q    <= 31'd65536;
			radius_q     <= 31'd65536;
			cells_x_q    <= 13'd64;
			cells_y_q    <= 13'd64;
			cells_z_q    <= 13'd64;
			three_dims_q <= 1'b1;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_SPACING:  spacing_q    <= cfg_data;
					REG_KERNEL_RADIUS: radius_q     <= cfg_data;
					REG_GRID_CELLS_X:  cells_x_q    <= cfg_data[12:0];
					REG_GRID_CELLS_Y:  cells_y_q    <= cfg_data[12:0];
					REG_GRID_CELLS_Z:  cells_z_q    <= cfg_data[12:0];
					REG_THREE_DIMS:    three_dims_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						py_q   <= s_tdata[63:32];
						pz_q   <= s_tdata[95:64];
						axis_q <= 2'd0;
						cnt_q  <= 5'd0;
						acc_q  <= 32'd0;
						quo_q  <= s_tdata[31] ? (~s_tdata[31:0] + 32'd1) : s_tdata[31:0];
						neg_q  <= s_tdata[31];
						span_q <= (MAX_SPAN > 0) && (radius_q > s_eff);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					acc_q <= acc_n;
					quo_q <= {quo_q[30:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_DIVF;
					end
				end
				ST_DIVF: begin
					if (neg_q && acc_q != 32'd0) begin
						h_q   <= ~{2'b0, quo_q};
						rem_q <= s_eff - acc_q[30:0];
					end else if (neg_q) begin
						h_q   <= ~{2'b0, quo_q} + 34'd1;
						rem_q <= 31'd0;
					end else begin
						h_q   <= {2'b0, quo_q};
						rem_q <= acc_q[30:0];
					end
					if (axis_q == 2'd0) begin
						r2_q <= prod;
					end
					o_q     <= 2'd0;
					state_q <= ST_AXD;
				end
				ST_AXD: begin
					ax_q <= ax_abs[31:0];
					case (axis_q)
						2'd0: begin
							okx_q[o_q]  <= ax_lt && in_grid;
							idxx_q[o_q] <= cand[11:0];
						end
						2'd1: begin
							oky_q[o_q]  <= ax_lt && in_grid;
							idxy_q[o_q] <= cand[11:0];
						end
						default: begin
							okz_q[o_q]  <= ax_lt && in_grid;
							idxz_q[o_q] <= cand[11:0];
						end
					endcase
					state_q <= ST_AXM;
				end
				ST_AXM: begin
					case (axis_q)
						2'd0:    sqx_q[o_q] <= prod;
						2'd1:    sqy_q[o_q] <= prod;
						default: sqz_q[o_q] <= prod;
					endcase
					if (o_q != 2'd2) begin
						o_q     <= o_q + 2'd1;
						state_q <= ST_AXD;
					end else if (axis_q == 2'd0 || (axis_q == 2'd1 && three_dims_q)) begin
						axis_q  <= axis_q + 2'd1;
						cnt_q   <= 5'd0;
						acc_q   <= 32'd0;
						quo_q   <= pos_abs;
						neg_q   <= pos_next[31];
						state_q <= ST_DIV;
					end else begin
						ci_q    <= st;
						cj_q    <= st;
						ck_q    <= kst;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_go) begin
						if (pass) begin
							if (held_valid_q) begin
								out_cell_q  <= held_cell_q;
								out_cv_q    <= 1'b1;
								out_last_q  <= 1'b0;
							end
							held_cell_q  <= {k_e, idxy_q[cj_q], idxx_q[ci_q]};
							held_valid_q <= 1'b1;
						end
						if (ck_q != ken) begin
							ck_q <= ck_q + 2'd1;
						end else begin
							ck_q <= kst;
							if (cj_q != en) begin
								cj_q <= cj_q + 2'd1;
							end else begin
								cj_q <= st;
								if (ci_q != en) begin
									ci_q <= ci_q + 2'd1;
								end else begin
									state_q <= ST_FIN;
								end
							end
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_cell_q   <= held_valid_q ? held_cell_q : 36'd0;
						out_cv_q     <= held_valid_q;
						out_last_q   <= 1'b1;
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_cell_q};
	assign m_tuser  = out_cv_q;
	assign m_tlast  = out_last_q;

	// Nothing may be held back between positions.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !held_valid_q)
		else $error("held cell left over at idle");

	// An accepted position always starts with the x divide.
	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DIV && axis_q == 2'd0))
		else $error("accepted position did not start dividing");

	// An empty-list beat always closes the list.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("empty beat without tlast");

	// Walk offsets stay within the three candidates.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (ci_q != 2'd3 && cj_q != 2'd3 && ck_q != 2'd3))
		else $error("walk offset out of range");

endmodule
`default_nettype wire

// ===== bench/grid_cells_within_kernel_radius_unit_checker.sv =====
// Checker for the grid-cells-within-kernel-radius unit: shadows the registers and
// predicts the cell list of every accepted position, then compares the output beats.
// Depends on gckr_pkg.
module grid_cells_within_kernel_radius_unit_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire gckr_pkg::cfg_idx_t          cfg_index,
	input  wire [gckr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                              s_tvalid,
	input  wire                              s_tready,
	input  wire [95:0]                       s_tdata,
	input  wire                              m_tvalid,
	input  wire                              m_tready,
	input  wire [39:0]                       m_tdata,
	input  wire                              m_tuser,
	input  wire                              m_tlast,
	output int                               fail_count,
	output int                               cells_pending
);
	import gckr_pkg::*;

	typedef struct packed {
		logic [11:0] ci;
		logic [11:0] cj;
		logic [11:0] ck;
		logic        valid;
		logic        last;
	} cell_beat_t;

	cell_beat_t expected_cells[$];

	logic [30:0] spacing_q, radius_q;
	logic [12:0] cells_x_q, cells_y_q, cells_z_q;
	logic        three_dims_q;

	function automatic longint clamp_dim(logic [12:0] v);
		return (v > 13'd4096) ? 64'sd4096 : longint'(v);
	endfunction

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	// Distance from the position to the cell center at doubled scale, so the
	// half-cell offset stays an integer.
	function automatic longint unsigned center_dist(longint p, longint idx, longint s);
		longint d;
		d = 2 * p - (2 * idx * s + s);
		return (d < 0) ? longint'(-d) : longint'(d);
	endfunction

	function automatic void list_cells(logic [95:0] d);
		longint s, r, px, py, pz, nx, ny, nz, hx, hy, hz, span, kspan;
		longint unsigned ax, ay, az, sum, t, lim, r2;
		bit carry, d3;
		cell_beat_t found[$];
		cell_beat_t c;
		s = (spacing_q == 0) ? 1 : longint'(spacing_q);
		r = longint'(radius_q);
		d3 = three_dims_q;
		px = longint'(signed'(d[31:0]));
		py = longint'(signed'(d[63:32]));
		pz = d3 ? longint'(signed'(d[95:64])) : 0;
		nx = clamp_dim(cells_x_q);
		ny = clamp_dim(cells_y_q);
		nz = d3 ? clamp_dim(cells_z_q) : 1;
		hx = floor_div(px, s);
		hy = floor_div(py, s);
		hz = d3 ? floor_div(pz, s) : 0;
		lim = 2 * r;
		r2 = lim * lim;
		if (r == 0) begin
			span = -1;
		end else begin
			span = (r + s - 1) / s - 1;
			if (span > 1)
				span = 1;
		end
		kspan = (span < 0) ? -1 : (d3 ? span : 0);
		for (longint i = hx - span; i <= hx + span; i++) begin
			for (longint j = hy - span; j <= hy + span; j++) begin
				for (longint k = hz - kspan; k <= hz + kspan; k++) begin
					if (i < 0 || i >= nx || j < 0 || j >= ny || k < 0 || k >= nz)
						continue;
					ax = center_dist(px, i, s);
					ay = center_dist(py, j, s);
					az = d3 ? center_dist(pz, k, s) : 0;
					if (ax >= lim || ay >= lim || az >= lim)
						continue;
					carry = 0;
					sum = ax * ax;
					t = ay * ay;
					sum += t;
					if (sum < t)
						carry = 1;
					t = az * az;
					sum += t;
					if (sum < t)
						carry = 1;
					if (carry || sum >= r2)
						continue;
					c.ci = i[11:0];
					c.cj = j[11:0];
					c.ck = k[11:0];
					c.valid = 1;
					c.last = 0;
					found = {found, c};
				end
			end
		end
		if (found.size() == 0) begin
			c = '0;
			c.last = 1;
			found = {found, c};
		end else begin
			c = found.pop_back();
			c.last = 1;
			found = {found, c};
		end
		expected_cells = {expected_cells, found};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_beat_t got, want;
		if (!arst_n) begin
			spacing_q <= 31'd65536;
			radius_q <= 31'd65536;
			cells_x_q <= 13'd64;
			cells_y_q <= 13'd64;
			cells_z_q <= 13'd64;
			three_dims_q <= 1'b1;
			fail_count <= 0;
			cells_pending <= 0;
			expected_cells.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[11:0], m_tdata[23:12], m_tdata[35:24], m_tuser, m_tlast};
				if (expected_cells.size() == 0) begin
					$display("%0t: unexpected cell beat i=%0d j=%0d k=%0d valid=%0b last=%0b",
						$time, got.ci, got.cj, got.ck, got.valid, got.last);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_cells.pop_front();
					if (got !== want) begin
						$display("%0t: cell mismatch expected i=%0d j=%0d k=%0d valid=%0b last=%0b",
							$time, want.ci, want.cj, want.ck, want.valid, want.last);
						$display("%0t:               actual i=%0d j=%0d k=%0d valid=%0b last=%0b",
							$time, got.ci, got.cj, got.ck, got.valid, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				list_cells(s_tdata);
			cells_pending <= expected_cells.size();
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_SPACING:  spacing_q <= cfg_data;
					REG_KERNEL_RADIUS: radius_q <= cfg_data;
					REG_GRID_CELLS_X:  cells_x_q <= cfg_data[12:0];
					REG_GRID_CELLS_Y:  cells_y_q <= cfg_data[12:0];
					REG_GRID_CELLS_Z:  cells_z_q <= cfg_data[12:0];
					REG_THREE_DIMS:    three_dims_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== bench/grid_cells_within_kernel_radius_unit_tb.sv =====
// Testbench top for the grid-cells-within-kernel-radius unit: drives positions and
// register writes, idles both stream sides, and reports the checker's verdict.
// Depends on gckr_pkg, the unit and grid_cells_within_kernel_radius_unit_checker.
module grid_cells_within_kernel_radius_unit_tb;
	import gckr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_idx_t    cfg_index = REG_GRID_SPACING;
	logic [30:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          cells_pending;

	// Idle and stall rates in percent, plus a request for one long hold-off
	// on the output side.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off_req = 0;
	int          quiet_cycles = 0;

	// Shadows of the spacing and the x cell count so that random positions land near the grid.
	longint      cur_spacing = 65536;
	longint      cur_cells = 64;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	grid_cells_within_kernel_radius_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	grid_cells_within_kernel_radius_unit_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.cells_pending (cells_pending)
	);

	// Output side: random stalls, and on request a long hold-off counted here so
	// the unit backs up and stops taking positions.
	initial begin
		int held;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				for (held = 0; held < 400; held++)
					@(negedge clk);
				hold_off_req = 0;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a long stretch with no beat on either side ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("** grid_cells_within_kernel_radius_unit: FAILED **");
			$finish;
		end
	end

	// One beat of positions; valid stays high from one beat to the next unless
	// an idle gap is drawn.
	task automatic send_pos(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Waits until every expected cell has arrived and the unit has settled.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cells_pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_GRID_SPACING)
			cur_spacing = (val == 0) ? 1 : longint'(val);
		if (idx == REG_GRID_CELLS_X)
			cur_cells = (val[12:0] == 0) ? 1 : longint'(val[12:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(input logic [30:0] sp, input logic [30:0] rad, input logic [12:0] nx,
			input logic [12:0] ny, input logic [12:0] nz, input logic d3);
		write_reg(REG_GRID_SPACING, sp);
		write_reg(REG_KERNEL_RADIUS, rad);
		write_reg(REG_GRID_CELLS_X, {18'd0, nx});
		write_reg(REG_GRID_CELLS_Y, {18'd0, ny});
		write_reg(REG_GRID_CELLS_Z, {18'd0, nz});
		write_reg(REG_THREE_DIMS, {30'd0, d3});
	endtask

	// A coordinate near the grid: a cell from just outside to just past the end,
	// plus a random offset within that cell.
	function automatic logic [31:0] near_grid();
		longint c, v;
		c = longint'($urandom_range(0, cur_cells + 3)) - 2;
		v = c * cur_spacing + longint'($urandom_range(0, cur_spacing - 1));
		return v[31:0];
	endfunction

	task automatic random_positions(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 85)
				send_pos(near_grid(), near_grid(), near_grid());
			else
				send_pos($urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [30:0] sp, rad;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset settings: cell centers, corners, the grid
		// edges, positions off the grid, and the extreme coordinates.
		send_pos(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		send_pos(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_pos(32'h003F_FFFF, 32'h003F_8000, 32'h003F_0000);
		send_pos(32'hFFFF_FFFF, 32'hFFFF_8000, 32'h0000_4000);
		send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pos(32'h0040_0000, 32'h0010_0000, 32'h0010_0000);
		drain();
		// Wide kernel in 2-D mode; the z coordinate must not matter.
		setup(31'h0001_0000, 31'h0002_0000, 13'd4096, 13'd8191, 13'd0, 1'b0);
		send_pos(32'h0000_8000, 32'h0000_8000, 32'hDEAD_BEEF);
		send_pos(32'h0FFF_8000, 32'h0FFF_C000, 32'h0000_0000);
		send_pos(32'h0010_4000, 32'h0020_C000, 32'h1234_5678);
		drain();
		// Zero spacing acts as one; zero radius gives an empty list; an empty grid
		// along z gives an empty list too.
		setup(31'd0, 31'd3, 13'd64, 13'd64, 13'd64, 1'b1);
		send_pos(32'd5, 32'd7, 32'd9);
		drain();
		write_reg(REG_KERNEL_RADIUS, 31'd0);
		send_pos(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		drain();
		setup(31'h0001_0000, 31'h0001_8000, 13'd4, 13'd4, 13'd0, 1'b1);
		send_pos(32'h0001_8000, 32'h0001_8000, 32'h0000_8000);
		drain();
		// Largest spacing and radius, one-cell grid.
		setup(31'h7FFF_FFFF, 31'h7FFF_FFFF, 13'd1, 13'd1, 13'd1, 1'b1);
		send_pos(32'h3FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
		send_pos(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		drain();

		// Random phases, each with its own settings and one of four idling mixes.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			sp = 31'($urandom_range(32'h0000_0400, 32'h0004_0000));
			rad = 31'((longint'(sp) * $urandom_range(20, 260)) / 100 + 1);
			if (ph == 7) begin
				sp = 31'($urandom);
				rad = 31'($urandom);
			end
			setup(sp, rad, 13'($urandom_range(1, 24)), 13'($urandom_range(1, 24)),
				13'($urandom_range(1, 24)), ph != 3);
			if (ph == 5)
				setup(sp, rad, 13'($urandom_range(4097, 8191)), 13'd4096,
					13'($urandom), 1'b1);
			if (ph == 2) begin
				// Hold the output back while positions keep coming.
				hold_off_req = 1;
				random_positions(20);
				drain();
				random_positions(40);
			end else if (ph == 4) begin
				random_positions(30);
				drain();
				random_positions(30);
			end else begin
				random_positions(60);
			end
			drain();
		end

		if (fail_count == 0)
			$display("** grid_cells_within_kernel_radius_unit: PASSED **");
		else
			$display("** grid_cells_within_kernel_radius_unit: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
design/gckr_pkg.sv
design/grid_cells_within_kernel_radius_unit.sv
bench/grid_cells_within_kernel_radius_unit_checker.sv
bench/grid_cells_within_kernel_radius_unit_tb.sv
